### rtl/core/hrsf_pkg.sv
// HID report serial framer: shared types and frame constants.
// No dependencies; imported by every module of the block.
package hrsf_pkg;

  typedef enum logic [2:0] {
    KIND_KEY_PRESS       = 3'd0,
    KIND_KEY_RELEASE     = 3'd1,
    KIND_KEY_RELEASE_ALL = 3'd2,
    KIND_MOUSE_PRESS     = 3'd3,
    KIND_MOUSE_RELEASE   = 3'd4,
    KIND_MOUSE_REL_ALL   = 3'd5
  } kind_t;

  typedef struct packed {
    logic       apply;
    kind_t      kind;
    logic [7:0] code;
  } key_evt_t;

  localparam logic [7:0] HDR0       = 8'h57;
  localparam logic [7:0] HDR1       = 8'hAB;
  localparam logic [7:0] ADDR       = 8'h00;
  localparam logic [7:0] CMD_KBD    = 8'h02;
  localparam logic [7:0] CMD_MOUSE  = 8'h05;
  localparam logic [7:0] MOUSE_LEN  = 8'h05;
  localparam logic [7:0] MOUSE_FLAG = 8'h01;

  // header bytes plus report bytes, checksum excluded
  localparam int MOUSE_BODY = 10;

endpackage

### rtl/core/hrsf_if.sv
// HID report serial framer: valid/ready channel interfaces.
// Event channel (kind, code) and frame byte channel (frame_byte, last_byte).
interface hrsf_ev_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] code;
  modport source (output valid, kind, code, input ready);
  modport sink   (input valid, kind, code, output ready);
endinterface

interface hrsf_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;
  modport source (output valid, frame_byte, last_byte, input ready);
  modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

### rtl/core/hrsf_report_state.sv
// HID report serial framer: key slot table and mouse button mask.
// Depends on hrsf_pkg; gives the post-event state to the frame builder.
module hrsf_report_state #(
  parameter int KEY_SLOT_COUNT = 6
) (
  input  logic            clk,
  input  logic            rst,
  input  hrsf_pkg::key_evt_t evt,
  output logic [7:0]      slots_next [KEY_SLOT_COUNT],
  output logic [7:0]      buttons_next
);
  import hrsf_pkg::*;

  logic [7:0] slots [KEY_SLOT_COUNT];
  logic [7:0] buttons;
  logic       held;
  logic       placed;

  always_comb begin
    held   = 1'b0;
    placed = 1'b0;
    for (int i = 0; i < KEY_SLOT_COUNT; i++) begin
      slots_next[i] = slots[i];
      if (slots[i] == evt.code) held = 1'b1;
    end
    buttons_next = buttons;
    unique case (evt.kind)
      KIND_KEY_PRESS: begin
        if (evt.code != 8'd0 && !held) begin
          for (int i = 0; i < KEY_SLOT_COUNT; i++) begin
            if (!placed && slots[i] == 8'd0) begin
              slots_next[i] = evt.code;
              placed        = 1'b1;
            end
          end
        end
      end
      KIND_KEY_RELEASE: begin
        if (evt.code != 8'd0) begin
          for (int i = 0; i < KEY_SLOT_COUNT; i++)
            if (slots[i] == evt.code) slots_next[i] = 8'd0;
        end
      end
      KIND_KEY_RELEASE_ALL: begin
        for (int i = 0; i < KEY_SLOT_COUNT; i++) slots_next[i] = 8'd0;
      end
      KIND_MOUSE_PRESS:   buttons_next = buttons | evt.code;
      KIND_MOUSE_RELEASE: buttons_next = buttons & ~evt.code;
      KIND_MOUSE_REL_ALL: buttons_next = 8'd0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KEY_SLOT_COUNT; i++) slots[i] <= 8'd0;
      buttons <= 8'd0;
    end else if (evt.apply) begin
      for (int i = 0; i < KEY_SLOT_COUNT; i++) slots[i] <= slots_next[i];
      buttons <= buttons_next;
    end
  end

endmodule

### rtl/core/hid_report_serial_framer.sv
// HID report serial framer: top level, input register and byte serializer.
// Depends on hrsf_pkg, hrsf_if and hrsf_report_state.
//
// Usage:
//   ev    : one item per keyboard or mouse event (kind, code).
//   frame : one item per frame byte; last_byte marks the checksum byte.
// Every keyboard event gives a frame of KEY_SLOT_COUNT + 8 bytes, every mouse
// event a frame of 11 bytes; kinds 6 and 7 are taken and dropped silently.
// Path: a taken item waits in the input register until the serializer is free,
// is loaded into the frame buffer, and its bytes then pass the output register.
// Throughput: one frame byte per cycle out of the output register while
// frame.ready is high; the next frame is loaded in the cycle its
// predecessor's checksum byte moves out.
// One further item waits in the input register while a frame is sent.
// Stall: while frame.ready is low the output byte holds and the serializer
// stops; ev.ready drops while the input register is full and cannot load.
// Reset: clears the key slots, the button mask and all valid state.
module hid_report_serial_framer #(
  parameter int KEY_SLOT_COUNT = 6
) (
  input logic           clk,
  input logic           rst,
  hrsf_ev_if.sink       ev,
  hrsf_frame_if.source  frame
);
  import hrsf_pkg::*;

  localparam int FRAME_BODY = KEY_SLOT_COUNT + 7;
  localparam int BUF_DEPTH  = (FRAME_BODY > MOUSE_BODY) ? FRAME_BODY : MOUSE_BODY;
  localparam int REM_W      = $clog2(BUF_DEPTH + 2);

  logic              a_valid;
  kind_t             a_kind;
  logic [7:0]        a_code;

  logic [7:0]        buf_q [BUF_DEPTH];
  logic [7:0]        frame_bytes [BUF_DEPTH];
  logic [7:0]        sum;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  rem_next;
  logic [REM_W-1:0]  load_rem;

  logic              o_valid;
  logic [7:0]        o_byte;
  logic              o_last;

  logic              out_adv;
  logic              push;
  logic              load_ok;
  logic              is_kbd;
  logic              is_mouse;
  logic              load;

  key_evt_t          evt;
  logic [7:0]        slots_next [KEY_SLOT_COUNT];
  logic [7:0]        buttons_next;

  assign out_adv  = !o_valid || frame.ready;
  assign push     = out_adv && (rem != '0);
  assign load_ok  = (rem == '0) || ((rem == REM_W'(1)) && out_adv);
  assign is_kbd   = (a_kind == KIND_KEY_PRESS) || (a_kind == KIND_KEY_RELEASE) ||
                    (a_kind == KIND_KEY_RELEASE_ALL);
  assign is_mouse = (a_kind == KIND_MOUSE_PRESS) || (a_kind == KIND_MOUSE_RELEASE) ||
                    (a_kind == KIND_MOUSE_REL_ALL);
  assign load     = a_valid && load_ok && (is_kbd || is_mouse);
  assign ev.ready = !a_valid || load_ok;

  assign evt.apply = load;
  assign evt.kind  = a_kind;
  assign evt.code  = a_code;

  hrsf_report_state #(
    .KEY_SLOT_COUNT(KEY_SLOT_COUNT)
  ) u_state (
    .clk          (clk),
    .rst          (rst),
    .evt          (evt),
    .slots_next   (slots_next),
    .buttons_next (buttons_next)
  );

  always_comb begin
    for (int i = 0; i < BUF_DEPTH; i++) frame_bytes[i] = 8'd0;
    frame_bytes[0] = HDR0;
    frame_bytes[1] = HDR1;
    frame_bytes[2] = ADDR;
    if (is_kbd) begin
      frame_bytes[3] = CMD_KBD;
      frame_bytes[4] = 8'(KEY_SLOT_COUNT + 2);
      for (int i = 0; i < KEY_SLOT_COUNT; i++) frame_bytes[7 + i] = slots_next[i];
      load_rem = REM_W'(FRAME_BODY + 1);
    end else begin
      frame_bytes[3] = CMD_MOUSE;
      frame_bytes[4] = MOUSE_LEN;
      frame_bytes[5] = MOUSE_FLAG;
      frame_bytes[6] = buttons_next;
      load_rem = REM_W'(MOUSE_BODY + 1);
    end
  end

  always_comb begin
    rem_next = push ? rem - REM_W'(1) : rem;
    if (load) rem_next = load_rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      o_valid <= 1'b0;
      rem     <= '0;
    end else begin
      if (ev.ready) a_valid <= ev.valid;
      if (out_adv) o_valid <= (rem != '0);
      rem <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ev.valid && ev.ready) begin
      a_kind <= kind_t'(ev.kind);
      a_code <= ev.code;
    end
    if (push) begin
      o_byte <= (rem == REM_W'(1)) ? sum : buf_q[0];
      o_last <= (rem == REM_W'(1));
    end
    if (load) begin
      for (int i = 0; i < BUF_DEPTH; i++) buf_q[i] <= frame_bytes[i];
      sum <= 8'd0;
    end else if (push && rem != REM_W'(1)) begin
      for (int i = 0; i < BUF_DEPTH - 1; i++) buf_q[i] <= buf_q[i + 1];
      buf_q[BUF_DEPTH - 1] <= 8'd0;
      sum <= sum + buf_q[0];
    end
  end

  assign frame.valid      = o_valid;
  assign frame.frame_byte = o_byte;
  assign frame.last_byte  = o_last;

endmodule

### rtl/core/hrsf_checker.sv
// HID report serial framer: port-level checker and its bind to the top level.
// Depends on hrsf_pkg; watches the frame channel for stall hold, header, checksum and reset idle.
module hrsf_checker (
  input logic       clk,
  input logic       rst,
  input logic       frm_valid,
  input logic       frm_ready,
  input logic [7:0] frm_byte,
  input logic       frm_last
);
  import hrsf_pkg::*;

  logic       at_start;
  logic [7:0] run_sum;
  logic       frm_acc;

  assign frm_acc = frm_valid && frm_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      at_start <= 1'b1;
      run_sum  <= 8'd0;
    end else if (frm_acc) begin
      at_start <= frm_last;
      run_sum  <= frm_last ? 8'd0 : run_sum + frm_byte;
    end
  end

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    frm_valid && !frm_ready |=> frm_valid)
    else $error("frame valid dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    frm_valid && !frm_ready |=> $stable(frm_byte) && $stable(frm_last))
    else $error("frame payload changed while stalled");

  a_header: assert property (@(posedge clk) disable iff (rst)
    frm_acc && at_start |-> frm_byte == HDR0 && !frm_last)
    else $error("frame does not open with header byte");

  a_checksum: assert property (@(posedge clk) disable iff (rst)
    frm_acc && frm_last |-> frm_byte == run_sum)
    else $error("checksum byte mismatch");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !frm_valid)
    else $error("frame valid right after reset");

endmodule

bind hid_report_serial_framer hrsf_checker u_hrsf_checker (
  .clk       (clk),
  .rst       (rst),
  .frm_valid (frame.valid),
  .frm_ready (frame.ready),
  .frm_byte  (frame.frame_byte),
  .frm_last  (frame.last_byte)
);
